// File: src/svbpt_pkg.sv
// Package for the servo bus packet transaction block.
// Holds the request/result item types, command and status codes and framing constants.
// Used by every module in src; has no dependencies of its own.
package svbpt_pkg;

   // Raw opcode values on the request port.
   localparam logic [1:0] OPC_START = 2'd0;
   localparam logic [1:0] OPC_BYTE  = 2'd1;
   localparam logic [1:0] OPC_TICK  = 2'd2;

   // Framing constants.
   localparam logic [7:0]  HDR_BYTE       = 8'hFF;
   localparam logic [7:0]  BROADCAST_ID   = 8'hFE;
   localparam logic [7:0]  READ_DATA      = 8'h02;
   localparam logic [3:0]  FRAME_OVERHEAD = 4'd6;
   localparam logic [7:0]  LEN_BASE       = 8'h02;
   localparam logic [7:0]  MAX_READ_LEN   = 8'd251;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd15;
   localparam logic [15:0] TICKS_MAX      = 16'hFFFF;

   // Depth of the small queues on either side of the sequencer.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_START,
      CMD_BYTE,
      CMD_TICK
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_TIMEOUT  = 3'd1,
      ST_ECHO     = 3'd2,
      ST_PROTO    = 3'd3,
      ST_CHECKSUM = 3'd4
   } status_type;

   typedef enum logic {
      KIND_TX       = 1'b0,
      KIND_COMPLETE = 1'b1
   } kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_SEND
   } back_state_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] servo_id;
      logic [7:0] instruction;
      logic [7:0] arg0;
      logic [7:0] arg1;
      logic [7:0] arg2;
      logic [1:0] arg_count;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      kind_type   result_kind;
      logic [7:0] tx_byte;
      logic       tx_last;
      status_type status_code;
      logic [7:0] servo_error;
      logic [7:0] param_low;
      logic [7:0] param_high;
   } rsp_item_type;

endpackage

// File: src/svbpt_front.sv
// Front end of the servo bus transaction block: accepts and classifies requests.
// Requests with a meaningless opcode are taken and dropped; the rest wait in a short queue.
// Depends on svbpt_pkg.
module svbpt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [1:0]           opcode,
   input  logic [7:0]           servo_id,
   input  logic [7:0]           instruction,
   input  logic [7:0]           arg0,
   input  logic [7:0]           arg1,
   input  logic [7:0]           arg2,
   input  logic [1:0]           arg_count,
   input  logic [7:0]           rx_byte,
   output logic                 item_valid,
   output svbpt_pkg::req_item_type item,
   input  logic                 item_pop
);
   import svbpt_pkg::*;

   req_item_type            store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   req_item_type            incoming;
   logic                    known_op;
   logic                    wr_en;
   logic                    rd_en;

   always_comb begin
      known_op = 1'b1;
      incoming.cmd = CMD_START;
      case (opcode)
         OPC_START: incoming.cmd = CMD_START;
         OPC_BYTE:  incoming.cmd = CMD_BYTE;
         OPC_TICK:  incoming.cmd = CMD_TICK;
         default:   known_op = 1'b0;
      endcase
      incoming.servo_id    = servo_id;
      incoming.instruction = instruction;
      incoming.arg0        = arg0;
      incoming.arg1        = arg1;
      incoming.arg2        = arg2;
      incoming.arg_count   = arg_count;
      incoming.rx_byte     = rx_byte;
   end

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = store_ff[rd_ptr_ff];
   assign wr_en      = push && !full && known_op;
   assign rd_en      = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

// File: src/svbpt_back.sv
// Transaction sequencer of the servo bus block: frames and sends the packet,
// checks echo and reply bytes, counts ticks and raises the completion result.
// Depends on svbpt_pkg.
module svbpt_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  svbpt_pkg::req_item_type item,
   output logic                    item_pop,
   input  logic                    res_full,
   output logic                    res_push,
   output svbpt_pkg::rsp_item_type result,
   input  logic                    csr_valid,
   input  logic [15:0]             csr_data
);
   import svbpt_pkg::*;

   back_state_type state_ff, state_in;
   logic        busy_ff, busy_in;
   logic [15:0] timeout_ff, timeout_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  instr_ff, instr_in;
   logic [7:0]  a0_ff, a0_in;
   logic [7:0]  a1_ff, a1_in;
   logic [7:0]  a2_ff, a2_in;
   logic [1:0]  argc_ff, argc_in;
   logic [7:0]  chk_ff, chk_in;
   logic [3:0]  len_ff, len_in;
   logic [8:0]  exp_ff, exp_in;
   logic [8:0]  rcv_ff, rcv_in;
   logic [7:0]  rsum_ff, rsum_in;
   status_type  fail_ff, fail_in;
   logic [7:0]  cap0_ff, cap0_in;
   logic [7:0]  cap1_ff, cap1_in;
   logic [7:0]  cap2_ff, cap2_in;
   logic        limp_ff, limp_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [3:0]  tx_idx_ff, tx_idx_in;

   logic        take;
   logic        tx_last;
   logic [7:0]  start_sum;
   logic [3:0]  start_len;
   logic [8:0]  reply_total;
   logic [8:0]  j;
   logic [8:0]  size;
   logic [8:0]  rcv_next;
   logic [15:0] elapsed_next;
   logic        in_echo;
   logic        echo_bad;
   logic        proto_bad;
   logic        is_chk;
   logic        chk_bad;
   status_type  byte_code;
   status_type  fail_next;
   logic        byte_done;
   logic        tick_done;
   logic        complete;
   status_type  done_status;

   // Byte of the stored outgoing packet at a given position.
   function automatic logic [7:0] packet_byte(input logic [3:0] idx, input logic [3:0] len,
                                             input logic [7:0] id, input logic [7:0] instr,
                                             input logic [1:0] argc, input logic [7:0] b0,
                                             input logic [7:0] b1, input logic [7:0] b2,
                                             input logic [7:0] chk);
      logic [7:0] val;
      val = chk;
      if (idx != len - 4'd1) begin
         case (idx)
            4'd0, 4'd1: val = HDR_BYTE;
            4'd2:       val = id;
            4'd3:       val = LEN_BASE + {6'd0, argc};
            4'd4:       val = instr;
            4'd5:       val = b0;
            4'd6:       val = b1;
            4'd7:       val = b2;
            default:    val = chk;
         endcase
      end
      return val;
   endfunction

   assign take    = (state_ff == BK_IDLE) && item_valid && !res_full;
   assign tx_last = (tx_idx_ff == len_ff - 4'd1);

   // Start: packet and reply lengths, and checksum over id, length, instruction and the arguments in use.
   always_comb begin
      start_len = FRAME_OVERHEAD + {2'd0, item.arg_count};
      start_sum = item.servo_id + (LEN_BASE + {6'd0, item.arg_count}) + item.instruction;
      if (item.arg_count > 2'd0) begin
         start_sum = start_sum + item.arg0;
      end
      if (item.arg_count > 2'd1) begin
         start_sum = start_sum + item.arg1;
      end
      if (item.arg_count > 2'd2) begin
         start_sum = start_sum + item.arg2;
      end
      reply_total = '0;
      if (item.servo_id != BROADCAST_ID) begin
         if (item.instruction != READ_DATA) begin
            reply_total = {5'd0, FRAME_OVERHEAD};
         end else begin
            reply_total = {5'd0, FRAME_OVERHEAD} + {1'b0, item.arg1};
         end
      end
   end

   // Received byte: echo check first, then the reply framing and checksum; also the next tick count.
   always_comb begin
      in_echo   = (rcv_ff < {5'd0, len_ff});
      echo_bad  = (item.rx_byte != packet_byte(rcv_ff[3:0], len_ff, id_ff, instr_ff, argc_ff,
                                               a0_ff, a1_ff, a2_ff, chk_ff));
      j         = rcv_ff - {5'd0, len_ff};
      size      = exp_ff - {5'd0, len_ff};
      proto_bad = 1'b0;
      if ((j == 9'd0) || (j == 9'd1)) begin
         proto_bad = (item.rx_byte != HDR_BYTE);
      end else if (j == 9'd2) begin
         proto_bad = (item.rx_byte != id_ff);
      end else if (j == 9'd3) begin
         proto_bad = limp_ff || (item.rx_byte != (size[7:0] - 8'd4));
      end
      is_chk  = (j + 9'd1 == size);
      chk_bad = is_chk && (item.rx_byte != ~rsum_ff);
      if (in_echo) begin
         byte_code = echo_bad ? ST_ECHO : ST_OK;
      end else if (proto_bad) begin
         byte_code = ST_PROTO;
      end else if (chk_bad) begin
         byte_code = ST_CHECKSUM;
      end else begin
         byte_code = ST_OK;
      end
      fail_next = (fail_ff == ST_OK) ? byte_code : fail_ff;
      rcv_next  = rcv_ff + 9'd1;
      byte_done = (rcv_next >= exp_ff);

      elapsed_next = (elapsed_ff == TICKS_MAX) ? elapsed_ff : elapsed_ff + 16'd1;
      tick_done    = (elapsed_next >= timeout_ff);
   end

   always_comb begin
      complete    = 1'b0;
      done_status = ST_OK;
      if (take && busy_ff) begin
         case (item.cmd)
            CMD_BYTE: begin
               complete    = byte_done;
               done_status = fail_next;
            end
            CMD_TICK: begin
               complete    = tick_done;
               done_status = ST_TIMEOUT;
            end
            default: complete = 1'b0;
         endcase
      end
   end

   // Next state of the transmit sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (take && (item.cmd == CMD_START) && !busy_ff) begin
               state_in = BK_SEND;
            end
         end
         BK_SEND: begin
            if (!res_full && tx_last) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      item_pop = 1'b0;
      res_push = 1'b0;
      result   = '0;
      case (state_ff)
         BK_IDLE: begin
            item_pop = take;
            res_push = complete;
            result.result_kind = KIND_COMPLETE;
            result.status_code = done_status;
            if ((done_status == ST_OK) && (size != 9'd0)) begin
               result.servo_error = cap0_in;
               if ((size == 9'd7) || (size == 9'd8)) begin
                  result.param_low = cap1_in;
               end
               if (size == 9'd8) begin
                  result.param_high = cap2_in;
               end
            end
         end
         BK_SEND: begin
            res_push = !res_full;
            result.result_kind = KIND_TX;
            result.tx_byte = packet_byte(tx_idx_ff, len_ff, id_ff, instr_ff, argc_ff,
                                         a0_ff, a1_ff, a2_ff, chk_ff);
            result.tx_last = tx_last;
         end
         default: result = '0;
      endcase
   end

   // Datapath register updates.
   always_comb begin
      busy_in    = busy_ff;
      timeout_in = csr_valid ? csr_data : timeout_ff;
      id_in      = id_ff;
      instr_in   = instr_ff;
      a0_in      = a0_ff;
      a1_in      = a1_ff;
      a2_in      = a2_ff;
      argc_in    = argc_ff;
      chk_in     = chk_ff;
      len_in     = len_ff;
      exp_in     = exp_ff;
      rcv_in     = rcv_ff;
      rsum_in    = rsum_ff;
      fail_in    = fail_ff;
      cap0_in    = cap0_ff;
      cap1_in    = cap1_ff;
      cap2_in    = cap2_ff;
      limp_in    = limp_ff;
      elapsed_in = elapsed_ff;
      tx_idx_in  = tx_idx_ff;

      if (state_ff == BK_SEND) begin
         if (!res_full) begin
            tx_idx_in = tx_idx_ff + 4'd1;
         end
      end else if (take) begin
         case (item.cmd)
            CMD_START: begin
               if (!busy_ff) begin
                  busy_in    = 1'b1;
                  id_in      = item.servo_id;
                  instr_in   = item.instruction;
                  a0_in      = item.arg0;
                  a1_in      = item.arg1;
                  a2_in      = item.arg2;
                  argc_in    = item.arg_count;
                  chk_in     = ~start_sum;
                  len_in     = start_len;
                  exp_in     = {5'd0, start_len} + reply_total;
                  limp_in    = (item.servo_id != BROADCAST_ID) &&
                               (item.instruction == READ_DATA) && (item.arg1 > MAX_READ_LEN);
                  rcv_in     = '0;
                  rsum_in    = '0;
                  fail_in    = ST_OK;
                  cap0_in    = '0;
                  cap1_in    = '0;
                  cap2_in    = '0;
                  elapsed_in = '0;
                  tx_idx_in  = '0;
               end
            end
            CMD_BYTE: begin
               if (busy_ff) begin
                  rcv_in  = rcv_next;
                  fail_in = fail_next;
                  if (!in_echo && !is_chk && (j >= 9'd2)) begin
                     rsum_in = rsum_ff + item.rx_byte;
                     if (j == 9'd4) begin
                        cap0_in = item.rx_byte;
                     end
                     if (j == 9'd5) begin
                        cap1_in = item.rx_byte;
                     end
                     if (j == 9'd6) begin
                        cap2_in = item.rx_byte;
                     end
                  end
               end
            end
            CMD_TICK: begin
               if (busy_ff) begin
                  elapsed_in = elapsed_next;
               end
            end
            default: busy_in = busy_ff;
         endcase
         if (complete) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         busy_ff    <= 1'b0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         state_ff   <= state_in;
         busy_ff    <= busy_in;
         timeout_ff <= timeout_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff      <= id_in;
      instr_ff   <= instr_in;
      a0_ff      <= a0_in;
      a1_ff      <= a1_in;
      a2_ff      <= a2_in;
      argc_ff    <= argc_in;
      chk_ff     <= chk_in;
      len_ff     <= len_in;
      exp_ff     <= exp_in;
      rcv_ff     <= rcv_in;
      rsum_ff    <= rsum_in;
      fail_ff    <= fail_in;
      cap0_ff    <= cap0_in;
      cap1_ff    <= cap1_in;
      cap2_ff    <= cap2_in;
      limp_ff    <= limp_in;
      elapsed_ff <= elapsed_in;
      tx_idx_ff  <= tx_idx_in;
   end

endmodule

// File: src/svbpt_rsp_queue.sv
// Result queue of the servo bus transaction block.
// Holds finished results so the sequencer keeps working while the consumer stalls.
// Depends on svbpt_pkg.
module svbpt_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  svbpt_pkg::rsp_item_type wr_item,
   output logic                    full,
   output logic                    empty,
   output svbpt_pkg::rsp_item_type rd_item,
   input  logic                    pop
);
   import svbpt_pkg::*;

   rsp_item_type      store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_wr;
   logic              do_rd;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_item = store_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!do_wr && do_rd) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         store_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// File: src/servo_bus_packet_transaction.sv
// Servo bus packet transaction. A start request frames an instruction packet
// (FF FF, id, length, instruction, up to three arguments, inverted-sum checksum) and
// delivers it as transmit results, one byte per cycle while the result queue has room,
// so a start holds the sequencer until the last byte is out. Received-byte and tick
// requests are taken while the sequencer is idle: bytes are checked against the echo
// and then the reply, and the transaction ends with one completion result carrying
// the first failure, a timeout, or the reply's error byte and parameters. A two-entry
// request queue and a two-entry result queue let either side stall without holding up
// the other. Timeout is written on the csr_ port, which is always ready. Depends on
// svbpt_pkg, svbpt_front, svbpt_back and svbpt_rsp_queue.
module servo_bus_packet_transaction (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_servo_id,
   input  logic [7:0]  req_instruction,
   input  logic [7:0]  req_arg0,
   input  logic [7:0]  req_arg1,
   input  logic [7:0]  req_arg2,
   input  logic [1:0]  req_arg_count,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_last,
   output logic [2:0]  rsp_status_code,
   output logic [7:0]  rsp_servo_error,
   output logic [7:0]  rsp_param_low,
   output logic [7:0]  rsp_param_high,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_timeout_ticks
);
   import svbpt_pkg::*;

   logic         item_valid;
   req_item_type item;
   logic         item_pop;
   logic         res_full;
   logic         res_push;
   rsp_item_type result;
   rsp_item_type head;

   assign csr_ready = 1'b1;

   svbpt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .full        (req_full),
      .opcode      (req_opcode),
      .servo_id    (req_servo_id),
      .instruction (req_instruction),
      .arg0        (req_arg0),
      .arg1        (req_arg1),
      .arg2        (req_arg2),
      .arg_count   (req_arg_count),
      .rx_byte     (req_rx_byte),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop)
   );

   svbpt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .res_full   (res_full),
      .res_push   (res_push),
      .result     (result),
      .csr_valid  (csr_valid && csr_ready),
      .csr_data   (csr_timeout_ticks)
   );

   svbpt_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_item (result),
      .full    (res_full),
      .empty   (rsp_empty),
      .rd_item (head),
      .pop     (rsp_pop)
   );

   assign rsp_result_kind = head.result_kind;
   assign rsp_tx_byte     = head.tx_byte;
   assign rsp_tx_last     = head.tx_last;
   assign rsp_status_code = head.status_code;
   assign rsp_servo_error = head.servo_error;
   assign rsp_param_low   = head.param_low;
   assign rsp_param_high  = head.param_high;

endmodule
